>>> src/pgwm_pkg.sv
package pgwm_pkg;

  localparam int CODES_PER_BYTE = 4;
  localparam int WEIGHT_BITS    = 16;
  localparam int PROD_BITS      = WEIGHT_BITS + 2;
  localparam int SUM_BITS       = 34;
  localparam int TOTAL_BITS     = 33;
  localparam int FRAC_BITS      = 16;
  localparam int MEAN_BITS      = 18;
  localparam int NUM_BITS       = SUM_BITS + FRAC_BITS;

  localparam logic [1:0]           MISSING_CODE = 2'd3;
  localparam logic [MEAN_BITS-1:0] MEAN_MAX     = MEAN_BITS'(131072);

  typedef struct packed {
    logic [PROD_BITS-1:0]   prod;
    logic [WEIGHT_BITS-1:0] weight;
  } lane_out_t;

endpackage

>>> src/pgwm_lane.sv
module pgwm_lane (
  input  logic [1:0]                           code,
  input  logic [pgwm_pkg::WEIGHT_BITS-1:0]     weight,
  input  logic                                 enable,
  output pgwm_pkg::lane_out_t                  lane_out
);
  import pgwm_pkg::*;

  logic used;

  assign used = enable && (code != MISSING_CODE);

  // code is 0, 1 or 2 here: weight times code is a shift by code[1]
  always_comb begin
    if (used && (code != 2'd0)) begin
      lane_out.prod = PROD_BITS'(weight) << code[1];
    end else begin
      lane_out.prod = '0;
    end
    lane_out.weight = used ? weight : '0;
  end

endmodule

>>> src/pgwm_merge.sv
module pgwm_merge (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic                                 last,
  input  pgwm_pkg::lane_out_t                  lanes [pgwm_pkg::CODES_PER_BYTE],
  output logic [pgwm_pkg::SUM_BITS-1:0]        fin_sum,
  output logic [pgwm_pkg::TOTAL_BITS-1:0]      fin_total
);
  import pgwm_pkg::*;

  localparam int LANE_SUM_BITS = PROD_BITS + 2;
  localparam int LANE_W_BITS   = WEIGHT_BITS + 2;

  logic [SUM_BITS-1:0]      acc_sum;
  logic [TOTAL_BITS-1:0]    acc_total;
  logic [LANE_SUM_BITS-1:0] prod_sum;
  logic [LANE_W_BITS-1:0]   weight_sum;
  logic [SUM_BITS:0]        sum_wide;
  logic [TOTAL_BITS:0]      total_wide;
  logic [SUM_BITS-1:0]      sum_next;
  logic [TOTAL_BITS-1:0]    total_next;

  always_comb begin
    prod_sum   = '0;
    weight_sum = '0;
    for (int i = 0; i < CODES_PER_BYTE; i++) begin
      prod_sum   = prod_sum + LANE_SUM_BITS'(lanes[i].prod);
      weight_sum = weight_sum + LANE_W_BITS'(lanes[i].weight);
    end
    // all terms are nonnegative, so one clamp matches clamping each add
    sum_wide   = {1'b0, acc_sum} + (SUM_BITS+1)'(prod_sum);
    total_wide = {1'b0, acc_total} + (TOTAL_BITS+1)'(weight_sum);
    sum_next   = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
    total_next = total_wide[TOTAL_BITS] ? '1 : total_wide[TOTAL_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_sum   <= '0;
      acc_total <= '0;
    end else if (accept) begin
      if (last) begin
        acc_sum   <= '0;
        acc_total <= '0;
      end else begin
        acc_sum   <= sum_next;
        acc_total <= total_next;
      end
    end
  end

  // hold the row totals for the divider and the result
  always_ff @(posedge clk) begin
    if (accept && last) begin
      fin_sum   <= sum_next;
      fin_total <= total_next;
    end
  end

endmodule

>>> src/pgwm_div.sv
module pgwm_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [pgwm_pkg::SUM_BITS-1:0]        sum,
  input  logic [pgwm_pkg::TOTAL_BITS-1:0]      total,
  output logic                                 busy,
  output logic [pgwm_pkg::MEAN_BITS-1:0]       quotient
);
  import pgwm_pkg::*;

  localparam int CNT_BITS = $clog2(MEAN_BITS + 1);

  logic [NUM_BITS-1:0]   num;
  logic [TOTAL_BITS-1:0] den;
  logic [TOTAL_BITS-1:0] rem;
  logic [TOTAL_BITS:0]   trial;
  logic                  fits;
  logic [CNT_BITS-1:0]   count;

  // round to nearest: add half the divisor before dividing
  assign num   = {sum, {FRAC_BITS{1'b0}}} + NUM_BITS'(total >> 1);
  assign trial = {rem, quotient[MEAN_BITS-1]};
  assign fits  = trial >= {1'b0, den};
  assign busy  = count != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_BITS'(MEAN_BITS);
    end else if (busy) begin
      count <= count - CNT_BITS'(1);
    end
  end

  // restoring divide, one quotient bit per cycle; the high part of the
  // numerator is known to be below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= TOTAL_BITS'(num[NUM_BITS-1:MEAN_BITS]);
      quotient <= num[MEAN_BITS-1:0];
      den      <= total;
    end else if (busy) begin
      rem      <= fits ? TOTAL_BITS'(trial - {1'b0, den}) : trial[TOTAL_BITS-1:0];
      quotient <= {quotient[MEAN_BITS-2:0], fits};
    end
  end

endmodule

>>> src/packed_genotype_weighted_mean.sv
// Channel  Handshake             Payload
// in       in_valid / in_ready   packed_genotypes, weight_a..weight_d, valid_count, last_in_row
// out      out_valid / out_ready mean_value, no_weight
//
// A byte that does not end a row is taken every cycle: four lanes and one
// saturating add into the accumulators. A byte that ends a row holds off the
// next request while the block loads the rounded numerator, runs 18 radix-2
// divide steps, sees the divider finish and writes the result.
// The next row accumulates while a result waits; a second row end stalls in
// the write step until out_ready takes the first. Reset is synchronous.
module packed_genotype_weighted_mean (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           packed_genotypes,
  input  logic [pgwm_pkg::WEIGHT_BITS-1:0]     weight_a,
  input  logic [pgwm_pkg::WEIGHT_BITS-1:0]     weight_b,
  input  logic [pgwm_pkg::WEIGHT_BITS-1:0]     weight_c,
  input  logic [pgwm_pkg::WEIGHT_BITS-1:0]     weight_d,
  input  logic [2:0]                           valid_count,
  input  logic                                 last_in_row,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pgwm_pkg::MEAN_BITS-1:0]       mean_value,
  output logic                                 no_weight
);
  import pgwm_pkg::*;

  typedef enum logic [3:0] {
    ST_ACC   = 4'b0001,
    ST_PREP  = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_WRITE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [WEIGHT_BITS-1:0] lane_weight [CODES_PER_BYTE];
  lane_out_t              lanes       [CODES_PER_BYTE];
  logic                   accept;
  logic [SUM_BITS-1:0]    fin_sum;
  logic [TOTAL_BITS-1:0]  fin_total;
  logic [MEAN_BITS-1:0]   quotient;
  logic                   div_start;
  logic                   div_busy;
  logic                   out_free;
  logic                   load_out;

  assign lane_weight[0] = weight_a;
  assign lane_weight[1] = weight_b;
  assign lane_weight[2] = weight_c;
  assign lane_weight[3] = weight_d;

  assign in_ready = state == ST_ACC;
  assign accept   = in_valid && in_ready;

  for (genvar i = 0; i < CODES_PER_BYTE; i++) begin : g_lane
    pgwm_lane u_lane (
      .code     (packed_genotypes[2*i +: 2]),
      .weight   (lane_weight[i]),
      .enable   (valid_count > 3'(i)),
      .lane_out (lanes[i])
    );
  end

  pgwm_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .last      (last_in_row),
    .lanes     (lanes),
    .fin_sum   (fin_sum),
    .fin_total (fin_total)
  );

  assign div_start = state == ST_PREP;

  pgwm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .sum      (fin_sum),
    .total    (fin_total),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign out_free = !out_valid || out_ready;
  assign load_out = (state == ST_WRITE) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACC:   if (accept && last_in_row) state_next = ST_PREP;
      ST_PREP:  state_next = ST_DIV;
      ST_DIV:   if (!div_busy) state_next = ST_WRITE;
      ST_WRITE: if (out_free) state_next = ST_ACC;
      default:  state_next = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the result until taken; clamp to 2.0, zero when no weight
  always_ff @(posedge clk) begin
    if (load_out) begin
      no_weight <= fin_total == '0;
      if (fin_total == '0) begin
        mean_value <= '0;
      end else if (quotient > MEAN_MAX) begin
        mean_value <= MEAN_MAX;
      end else begin
        mean_value <= quotient;
      end
    end
  end

endmodule

>>> test/tb_packed_genotype_weighted_mean.sv
`timescale 1ns / 1ps

module tb_packed_genotype_weighted_mean;
  import pgwm_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 24;
  localparam int RANDOM_REQUESTS = 760;
  localparam int LONG_ROW_BYTES  = 80;
  localparam int LONG_HOLD       = 300;

  typedef logic [CODES_PER_BYTE-1:0][WEIGHT_BITS-1:0] weight_set_t;

  typedef struct packed {
    logic [MEAN_BITS-1:0] mean;
    logic                 empty;
  } row_mean_t;

  class row_mean_predictor;
    logic [63:0] sum_acc;
    logic [63:0] weight_acc;
    row_mean_t   expected_means[$];
    int          failures;
    int          rows_done;
    int          empty_rows;
    int          clamped_rows;

    function new();
      sum_acc      = 0;
      weight_acc   = 0;
      failures     = 0;
      rows_done    = 0;
      empty_rows   = 0;
      clamped_rows = 0;
    endfunction

    function logic [63:0] sat_add(logic [63:0] acc, logic [63:0] add, logic [63:0] limit);
      if (add > limit || acc > limit - add) return limit;
      return acc + add;
    endfunction

    function int pending();
      return expected_means.size();
    endfunction

    function void take_request(logic [7:0] geno, weight_set_t w, logic [2:0] cnt,
                               logic last);
      logic [63:0] sum_max;
      logic [63:0] total_max;
      logic [63:0] num;
      logic [63:0] quo;
      logic [1:0]  code;
      int          lanes;
      row_mean_t   res;
      sum_max   = (64'd1 << SUM_BITS) - 1;
      total_max = (64'd1 << TOTAL_BITS) - 1;
      lanes     = (cnt > CODES_PER_BYTE) ? CODES_PER_BYTE : int'(cnt);
      for (int i = 0; i < CODES_PER_BYTE; i++) begin
        code = geno[2*i +: 2];
        if (i < lanes && code != MISSING_CODE) begin
          sum_acc    = sat_add(sum_acc, 64'(w[i]) * 64'(code), sum_max);
          weight_acc = sat_add(weight_acc, 64'(w[i]), total_max);
        end
      end
      if (!last) return;
      if (weight_acc == 0) begin
        res.mean  = '0;
        res.empty = 1'b1;
        empty_rows++;
      end else begin
        num = (sum_acc << FRAC_BITS) + (weight_acc >> 1);
        quo = num / weight_acc;
        if (quo > 64'(MEAN_MAX)) begin
          quo = 64'(MEAN_MAX);
          clamped_rows++;
        end
        res.mean  = quo[MEAN_BITS-1:0];
        res.empty = 1'b0;
      end
      expected_means.push_back(res);
      rows_done++;
      sum_acc    = 0;
      weight_acc = 0;
    endfunction

    function void check_mean(logic [MEAN_BITS-1:0] mean, logic empty);
      row_mean_t exp_res;
      if (expected_means.size() == 0) begin
        $error("unexpected result: mean_value=%0d no_weight=%0b", mean, empty);
        failures++;
        return;
      end
      exp_res = expected_means.pop_front();
      if (mean !== exp_res.mean) begin
        $error("mean_value: expected %0d, got %0d", exp_res.mean, mean);
        failures++;
      end
      if (empty !== exp_res.empty) begin
        $error("no_weight: expected %0b, got %0b", exp_res.empty, empty);
        failures++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic [7:0]                 packed_genotypes;
  logic [WEIGHT_BITS-1:0]     weight_a;
  logic [WEIGHT_BITS-1:0]     weight_b;
  logic [WEIGHT_BITS-1:0]     weight_c;
  logic [WEIGHT_BITS-1:0]     weight_d;
  logic [2:0]                 valid_count;
  logic                       last_in_row;
  logic                       out_valid;
  logic                       out_ready;
  logic [MEAN_BITS-1:0]       mean_value;
  logic                       no_weight;

  row_mean_predictor pred;
  int                requests_sent;
  int                long_hold_cycles;
  int                idle_cycles;

  packed_genotype_weighted_mean DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .packed_genotypes (packed_genotypes),
    .weight_a         (weight_a),
    .weight_b         (weight_b),
    .weight_c         (weight_c),
    .weight_d         (weight_d),
    .valid_count      (valid_count),
    .last_in_row      (last_in_row),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .mean_value       (mean_value),
    .no_weight        (no_weight)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        pred.take_request(packed_genotypes, {weight_d, weight_c, weight_b, weight_a},
                          valid_count, last_in_row);
      if (out_valid && out_ready) pred.check_mean(mean_value, no_weight);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, quiet stretches, and one long hold on request.
  initial begin
    int stall;
    int quiet_left;
    bit hold_taken;
    quiet_left = 0;
    hold_taken = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (long_hold_cycles > 0 && !hold_taken) begin
        stall = long_hold_cycles;
        hold_taken = 1'b1;
      end else if (quiet_left > 0) begin
        stall = 0;
        quiet_left--;
      end else begin
        stall = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) quiet_left = $urandom_range(1, 10);
      end
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_request(input logic [7:0] geno, input weight_set_t w,
                              input logic [2:0] cnt, input logic last, input int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    packed_genotypes <= geno;
    weight_a         <= w[0];
    weight_b         <= w[1];
    weight_c         <= w[2];
    weight_d         <= w[3];
    valid_count      <= cnt;
    last_in_row      <= last;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Hold the input idle until every row mean is back, then let the divider settle.
  task automatic drain_means();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pred.pending() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_random_row();
    int          len;
    int          style;
    bit          quiet;
    logic [7:0]  geno;
    weight_set_t w;
    logic [2:0]  cnt;
    quiet = ($urandom_range(0, 3) == 0);
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
    style = $urandom_range(0, 9);
    for (int i = 0; i < len; i++) begin
      geno = 8'($urandom_range(0, 255));
      for (int l = 0; l < CODES_PER_BYTE; l++) w[l] = WEIGHT_BITS'($urandom_range(0, 65535));
      if (style == 0) geno = 8'hFF;
      if (style == 1) w = '0;
      if (style == 2) w = '1;
      if ($urandom_range(0, 7) == 0) cnt = 3'($urandom_range(0, 7));
      else cnt = (i == len - 1) ? 3'($urandom_range(1, 4)) : 3'd4;
      send_request(geno, w, cnt, i == len - 1, quiet ? 0 : $urandom_range(0, 14));
    end
  endtask

  initial begin
    int          random_start;
    weight_set_t w;
    pred             = new();
    requests_sent    = 0;
    long_hold_cycles = 0;
    rst              = 1'b1;
    in_valid         = 1'b0;
    out_ready        = 1'b0;
    packed_genotypes = '0;
    weight_a         = '0;
    weight_b         = '0;
    weight_c         = '0;
    weight_d         = '0;
    valid_count      = '0;
    last_in_row      = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows
    send_request(8'b10_01_00_10, '1, 3'd4, 1'b1, 0);
    send_request(8'hFF, {16'd7, 16'd900, 16'hFFFF, 16'd1}, 3'd4, 1'b1, 3);
    send_request(8'b10_10_01_01, '0, 3'd4, 1'b1, 0);
    send_request(8'h00, '1, 3'd0, 1'b1, 5);
    send_request(8'hAA, {16'd4, 16'd3, 16'd2, 16'd1}, 3'd5, 1'b0, 0);
    send_request(8'h55, {16'd40, 16'd30, 16'd20, 16'd10}, 3'd6, 1'b0, 1);
    send_request(8'h1B, '1, 3'd7, 1'b1, 0);
    send_request(8'hFE, '1, 3'd1, 1'b1, 14);
    send_request(8'hF4, '1, 3'd2, 1'b1, 0);
    send_request(8'hE4, {16'hFFFF, 16'h8000, 16'h0001, 16'hFFFF}, 3'd3, 1'b1, 2);
    send_request(8'h00, '1, 3'd4, 1'b0, 0);
    send_request(8'hAA, '1, 3'd4, 1'b0, 0);
    send_request(8'h55, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 3'd4, 1'b0, 7);
    send_request(8'h9C, {16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0}, 3'd4, 1'b1, 0);
    send_request(8'hAA, '1, 3'd4, 1'b1, 0);
    send_request(8'h00, {16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00}, 3'd4, 1'b1, 9);
    send_request(8'hF1, {16'd0, 16'd0, 16'd1, 16'd1}, 3'd4, 1'b1, 0);
    send_request(8'hF1, {16'd0, 16'd0, 16'd2, 16'd3}, 3'd4, 1'b1, 0);
    send_request(8'hF2, {16'd5, 16'd5, 16'hFFFF, 16'd1}, 3'd4, 1'b1, 4);
    send_request(8'b00_11_10_11, {16'd100, 16'd200, 16'd300, 16'd400}, 3'd4, 1'b1, 0);
    drain_means();

    // back-pressure: result side holds off while one-byte rows keep coming
    long_hold_cycles = LONG_HOLD;
    for (int i = 0; i < 40; i++) begin
      for (int l = 0; l < CODES_PER_BYTE; l++) w[l] = WEIGHT_BITS'($urandom_range(0, 65535));
      send_request(8'($urandom_range(0, 255)), w, 3'($urandom_range(1, 4)), 1'b1, 0);
    end
    drain_means();

    // one long row of full-scale weights, bytes back to back
    for (int i = 0; i < LONG_ROW_BYTES; i++)
      send_request({2'($urandom_range(1, 2)), 2'($urandom_range(1, 2)),
                    2'($urandom_range(1, 2)), 2'($urandom_range(1, 2))},
                   '1, 3'd4, i == LONG_ROW_BYTES - 1, 0);
    drain_means();

    random_start = requests_sent;
    while (requests_sent - random_start < RANDOM_REQUESTS) begin
      send_random_row();
      if ($urandom_range(0, 39) == 0) drain_means();
    end
    drain_means();

    if (pred.pending() > 0) begin
      $error("%0d row means never arrived", pred.pending());
      pred.failures++;
    end
    $display("Sent %0d genotype bytes over %0d rows, one long row of full-scale weights.",
             requests_sent, pred.rows_done);
    $display("Rows with zero weight: %0d, rows with the mean clamped at 2.0: %0d.",
             pred.empty_rows, pred.clamped_rows);
    if (pred.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
